>>> rtl/gpg_pkg.sv
package gpg_pkg;

  localparam int MAX_STOPS   = 8;
  localparam int SLOT_W      = $clog2(MAX_STOPS);
  localparam int MIN_STOPS   = 2;
  localparam int POS_W       = 8;
  localparam int COLOR_W     = 24;
  localparam int CH_W        = 8;
  localparam int CNT_W       = 4;
  localparam int T_W         = 16;
  localparam int DIV_W       = 24;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int MUL_CNT_W   = $clog2(CH_W);
  localparam int ENTRY_W     = POS_W + COLOR_W;
  localparam int SUM_W       = T_W + 2;

  localparam logic [CNT_W-1:0]   STOP_CNT_RST = CNT_W'(MIN_STOPS);
  localparam logic [CH_W-1:0]    CH_MAX       = 8'hFF;
  localparam logic [COLOR_W-1:0] BLACK        = 24'h000000;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic [T_W-1:0] t_mag;
    logic           t_neg;
  } tval_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_RD_LO,
    ST_RD_HI,
    ST_CALC,
    ST_TDIV,
    ST_MIX_GO,
    ST_MIX,
    ST_OUT
  } gpg_state_t;

  typedef enum logic [1:0] {
    MX_IDLE,
    MX_MUL,
    MX_DIV_GO,
    MX_DIV
  } mix_state_t;

endpackage

>>> rtl/gpg_if.sv
interface gpg_in_if;
  import gpg_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [2:0]         stop_slot;
  logic [POS_W-1:0]   stop_position;
  logic [COLOR_W-1:0] stop_color;
  logic [POS_W-1:0]   palette_index;

  modport source (output valid, action, stop_slot, stop_position, stop_color, palette_index,
                  input ready);
  modport sink (input valid, action, stop_slot, stop_position, stop_color, palette_index,
                output ready);
endinterface

interface gpg_out_if;
  import gpg_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color;

  modport source (output valid, color, input ready);
  modport sink (input valid, color, output ready);
endinterface

interface gpg_cfg_if;
  import gpg_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] stop_count;

  modport source (output valid, stop_count, input ready);
  modport sink (input valid, stop_count, output ready);
endinterface

>>> rtl/gpg_div.sv
module gpg_div import gpg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [CH_W-1:0]    divisor,
  output logic               done,
  output logic [DIV_W-1:0]   quotient
);

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CH_W-1:0]      rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [CH_W-1:0]      dvs_r;

  logic [CH_W:0] trial;
  logic [CH_W:0] diff;
  logic          fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == '0);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= DIV_CNT_W'(DIV_W - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      // remainder stays below the divisor, so it fits in CH_W bits
      rem_r <= fits ? diff[CH_W-1:0] : trial[CH_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/gpg_mix.sv
module gpg_mix import gpg_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [CH_W-1:0] a,
  input  logic [CH_W-1:0] b,
  input  tval_t           t,
  output logic            done,
  output logic [CH_W-1:0] v
);

  mix_state_t state_r, state_nxt;

  logic [MUL_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     mcand_r;
  logic [CH_W-1:0]      mplier_r;
  logic [DIV_W-1:0]     acc_r;
  logic [CH_W-1:0]      a_r;
  logic                 neg_r;

  logic [CH_W:0]      diff9;
  logic [CH_W-1:0]    dmag;
  logic               div_start;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;
  logic [SUM_W-1:0]   sum;

  assign diff9 = {1'b0, b} - {1'b0, a};
  assign dmag  = diff9[CH_W] ? (~diff9[CH_W-1:0] + 1'b1) : diff9[CH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MX_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      MX_IDLE: begin
        if (start) state_nxt = MX_MUL;
      end
      MX_MUL: begin
        if (cnt_r == '0) state_nxt = MX_DIV_GO;
      end
      MX_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = MX_DIV;
      end
      MX_DIV: begin
        if (div_done) begin
          done      = 1'b1;
          state_nxt = MX_IDLE;
        end
      end
      default: state_nxt = MX_IDLE;
    endcase
  end

  // shift-add multiply of |b-a| by |t|, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (state_r == MX_IDLE && start) begin
      neg_r    <= diff9[CH_W] ^ t.t_neg;
      mcand_r  <= DIV_W'(t.t_mag);
      mplier_r <= dmag;
      acc_r    <= '0;
      a_r      <= a;
      cnt_r    <= MUL_CNT_W'(CH_W - 1);
    end else if (state_r == MX_MUL) begin
      if (mplier_r[0]) acc_r <= acc_r + mcand_r;
      mcand_r  <= {mcand_r[DIV_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[CH_W-1:1]};
      cnt_r    <= cnt_r - 1'b1;
    end
  end

  gpg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (CH_MAX),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (neg_r) begin
      sum = SUM_W'(a_r) - SUM_W'(div_q[T_W-1:0]);
    end else begin
      sum = SUM_W'(a_r) + SUM_W'(div_q[T_W-1:0]);
    end
    priority if (sum[SUM_W-1]) begin
      v = '0;
    end else if (|sum[SUM_W-2:CH_W]) begin
      v = CH_MAX;
    end else begin
      v = sum[CH_W-1:0];
    end
  end

endmodule

>>> rtl/gradient_palette_generator.sv
// Gradient palette generator: stop table plus bit-serial interpolation.
// in_if carries items; action load writes stop_slot with stop_position and
// stop_color and gives no result, action lookup gives one color on out_if.
// cfg_if writes stop_count (values below 2 act as 2, above the table size
// as the table size); it is always ready. The user must see that it is
// written only while idle; the block does not enforce it. A transfer
// happens when valid and ready are both high on a channel. A load writes
// the stop table at its transfer. A lookup of index 0 goes straight to the
// output state to load black into the output register, and the next item
// can transfer once the block is idle. Any other lookup scans the
// segments, reading each stop passed through the memory's single read
// port; a bit-serial divider forms t (skipped when the segment length is
// not positive) and each channel runs a shift-add multiply and a bit-serial
// divide by 255; the three channels work in parallel. One item is worked
// on at a time; in_if.ready is high only while the block is idle. The
// result sits in an output register, so new items are taken while it
// waits; a stalled receiver holds back the next lookup's result, and no
// item is taken while that waits. Reset sets stop_count to 2 and clears
// the control state; the stop table holds nothing meaningful until written.
module gradient_palette_generator import gpg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  gpg_in_if.sink    in_if,
  gpg_out_if.source out_if,
  gpg_cfg_if.sink   cfg_if
);

  gpg_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   stop_count_r;
  logic [ENTRY_W-1:0] stop_mem_r [MAX_STOPS];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [SLOT_W-1:0]  rd_addr;

  logic [SLOT_W-1:0]  seg_r;
  logic [SLOT_W-1:0]  lim_r;
  logic [POS_W-1:0]   idx_r;
  logic [POS_W-1:0]   start_r;
  logic [COLOR_W-1:0] c0_r;
  logic [COLOR_W-1:0] c1_r;
  logic [T_W-1:0]     t_mag_r;
  logic               t_neg_r;
  logic [COLOR_W-1:0] res_r;
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r;

  logic [SLOT_W-1:0]  lim_nxt;
  logic               in_xfer;
  logic               out_load;
  logic               tdiv_start;
  logic               mix_start;
  logic [POS_W-1:0]   rd_pos;
  logic [POS_W:0]     num9;
  logic [POS_W:0]     len9;
  logic [POS_W-1:0]   num_mag;
  logic [T_W-1:0]     num_x255;
  logic               len_pos;
  logic               tdiv_done;
  logic [DIV_W-1:0]   tdiv_q;
  tval_t              tval;
  logic [2:0]         mix_done;
  logic [CH_W-1:0]    mix_v [3];

  assign in_if.ready  = (state_r == ST_IDLE);
  assign in_xfer      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.color = out_color_r;

  always_comb begin
    priority if (stop_count_r < CNT_W'(MIN_STOPS)) begin
      lim_nxt = '0;
    end else if (int'(stop_count_r) > MAX_STOPS) begin
      lim_nxt = SLOT_W'(MAX_STOPS - MIN_STOPS);
    end else begin
      lim_nxt = SLOT_W'(stop_count_r - CNT_W'(MIN_STOPS));
    end
  end

  assign rd_pos   = rd_data_r[ENTRY_W-1:COLOR_W];
  assign num9     = {1'b0, idx_r} - {1'b0, start_r};
  assign len9     = {1'b0, rd_pos} - {1'b0, start_r};
  assign num_mag  = num9[POS_W] ? (~num9[POS_W-1:0] + 1'b1) : num9[POS_W-1:0];
  assign num_x255 = {num_mag, {POS_W{1'b0}}} - T_W'(num_mag);
  assign len_pos  = !len9[POS_W] && (len9 != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      stop_count_r <= STOP_CNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_if.valid && cfg_if.ready) stop_count_r <= cfg_if.stop_count;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rd_addr    = seg_r;
    tdiv_start = 1'b0;
    mix_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_if.action == ACT_LOOKUP) begin
          state_nxt = (in_if.palette_index == '0) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr   = seg_r + 1'b1;
        state_nxt = (seg_r < lim_r) ? ST_SCAN_CMP : ST_RD_LO;
      end
      ST_SCAN_CMP: begin
        state_nxt = (idx_r > rd_pos) ? ST_SCAN : ST_RD_LO;
      end
      ST_RD_LO: begin
        state_nxt = ST_RD_HI;
      end
      ST_RD_HI: begin
        rd_addr   = seg_r + 1'b1;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        tdiv_start = len_pos;
        state_nxt  = len_pos ? ST_TDIV : ST_MIX_GO;
      end
      ST_TDIV: begin
        if (tdiv_done) state_nxt = ST_MIX_GO;
      end
      ST_MIX_GO: begin
        mix_start = 1'b1;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        if (mix_done[0]) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_if.action == ACT_LOAD && int'(in_if.stop_slot) < MAX_STOPS) begin
      stop_mem_r[SLOT_W'(in_if.stop_slot)] <= {in_if.stop_position, in_if.stop_color};
    end
    rd_data_r <= stop_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        seg_r   <= '0;
        lim_r   <= lim_nxt;
        idx_r   <= in_if.palette_index;
        res_r   <= BLACK;
        t_mag_r <= '0;
        t_neg_r <= 1'b0;
      end
      ST_SCAN_CMP: begin
        if (idx_r > rd_pos) seg_r <= seg_r + 1'b1;
      end
      ST_RD_HI: begin
        start_r <= rd_pos;
        c0_r    <= rd_data_r[COLOR_W-1:0];
      end
      ST_CALC: begin
        c1_r    <= rd_data_r[COLOR_W-1:0];
        t_neg_r <= len_pos && num9[POS_W];
      end
      ST_TDIV: begin
        if (tdiv_done) t_mag_r <= tdiv_q[T_W-1:0];
      end
      ST_MIX: begin
        if (mix_done[0]) res_r <= {mix_v[2], mix_v[1], mix_v[0]};
      end
      default: ;
    endcase
    if (out_load) out_color_r <= res_r;
  end

  gpg_div u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (tdiv_start),
    .dividend (DIV_W'(num_x255)),
    .divisor  (len9[POS_W-1:0]),
    .done     (tdiv_done),
    .quotient (tdiv_q)
  );

  assign tval.t_mag = t_mag_r;
  assign tval.t_neg = t_neg_r;

  // lane 0 is blue, lane 2 is red
  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    gpg_mix u_mix (
      .clk   (clk),
      .rst_n (rst_n),
      .start (mix_start),
      .a     (c0_r[ch*CH_W +: CH_W]),
      .b     (c1_r[ch*CH_W +: CH_W]),
      .t     (tval),
      .done  (mix_done[ch]),
      .v     (mix_v[ch])
    );
  end

endmodule

>>> verif/tb_gradient_palette_generator.sv
`timescale 1ns / 100ps

module tb_gradient_palette_generator;
  import gpg_pkg::*;

  localparam int SETTLE_CYCLES = 120;
  localparam int PHASE_ITEMS   = 50;

  typedef struct {
    logic               action;
    logic [2:0]         slot;
    logic [POS_W-1:0]   pos;
    logic [COLOR_W-1:0] rgb;
    logic [POS_W-1:0]   idx;
    bit                 typed;
    logic [COLOR_W-1:0] typed_color;
  } palette_req_t;

  logic clk = 1'b0;
  logic rst_n;

  gpg_in_if  in_ch();
  gpg_out_if out_ch();
  gpg_cfg_if cfg_ch();

  gradient_palette_generator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block's stop table and register
  logic [POS_W-1:0]   stop_pos_tbl [MAX_STOPS];
  logic [COLOR_W-1:0] stop_rgb_tbl [MAX_STOPS];
  logic [CNT_W-1:0]   stop_count_cfg;

  logic [COLOR_W-1:0] pending_colors [$];
  int                 error_count;
  bit                 in_idle;
  bit                 out_idle;

  // hand-computed expectation travels with the payload of the transfer
  logic               req_typed;
  logic [COLOR_W-1:0] req_typed_color;

  palette_req_t directed_rows [25] = '{
    '{ACT_LOOKUP, 3'd0, 8'd0,   24'h000000, 8'd0,   1'b1, BLACK},       // zero straight from reset
    '{ACT_LOAD,   3'd0, 8'd0,   24'h000000, 8'd0,   1'b0, BLACK},
    '{ACT_LOAD,   3'd1, 8'd36,  24'hFFFFFF, 8'd0,   1'b0, BLACK},
    '{ACT_LOAD,   3'd2, 8'd73,  24'hFF0000, 8'd0,   1'b0, BLACK},
    '{ACT_LOAD,   3'd3, 8'd109, 24'h00FF00, 8'd0,   1'b0, BLACK},
    '{ACT_LOAD,   3'd4, 8'd146, 24'h0000FF, 8'd0,   1'b0, BLACK},
    '{ACT_LOAD,   3'd5, 8'd182, 24'h123456, 8'd0,   1'b0, BLACK},
    '{ACT_LOAD,   3'd6, 8'd219, 24'hFEDCBA, 8'd0,   1'b0, BLACK},
    '{ACT_LOAD,   3'd7, 8'd255, 24'hFFFFFF, 8'd0,   1'b0, BLACK},
    '{ACT_LOOKUP, 3'd0, 8'd0,   24'h000000, 8'd36,  1'b1, 24'hFFFFFF},  // segment end
    '{ACT_LOOKUP, 3'd0, 8'd0,   24'h000000, 8'd18,  1'b0, BLACK},
    '{ACT_LOOKUP, 3'd0, 8'd0,   24'h000000, 8'd255, 1'b1, 24'hFFFFFF},  // past last stop
    '{ACT_LOAD,   3'd0, 8'd200, 24'h102030, 8'd0,   1'b0, BLACK},
    '{ACT_LOAD,   3'd1, 8'd255, 24'hFFFFFF, 8'd0,   1'b0, BLACK},
    '{ACT_LOOKUP, 3'd0, 8'd0,   24'h000000, 8'd1,   1'b1, BLACK},       // far before start
    '{ACT_LOOKUP, 3'd0, 8'd0,   24'h000000, 8'd255, 1'b1, 24'hFFFFFF},
    '{ACT_LOOKUP, 3'd0, 8'd0,   24'h000000, 8'd230, 1'b0, BLACK},
    '{ACT_LOAD,   3'd1, 8'd100, 24'hABCDEF, 8'd0,   1'b0, BLACK},
    '{ACT_LOOKUP, 3'd0, 8'd0,   24'h000000, 8'd150, 1'b1, 24'h102030},  // descending stops
    '{ACT_LOAD,   3'd1, 8'd200, 24'h445566, 8'd0,   1'b0, BLACK},
    '{ACT_LOOKUP, 3'd0, 8'd0,   24'h000000, 8'd200, 1'b1, 24'h102030},  // equal stops
    '{ACT_LOAD,   3'd0, 8'd0,   24'h000000, 8'd0,   1'b0, BLACK},
    '{ACT_LOAD,   3'd1, 8'd10,  24'h808080, 8'd0,   1'b0, BLACK},
    '{ACT_LOOKUP, 3'd0, 8'd0,   24'h000000, 8'd255, 1'b1, 24'hFFFFFF},  // saturates high
    '{ACT_LOOKUP, 3'd0, 8'd0,   24'h000000, 8'd5,   1'b0, BLACK}
  };

  // out of range values act as the nearest legal count
  int cfg_plan [11] = '{8, 0, 15, 5, 1, 9, 3, 7, 2, 6, 4};

  function automatic logic [COLOR_W-1:0] palette_color(logic [POS_W-1:0] idx);
    int n, seg, start_p, end_p, span, t, a, b, v, ch;
    logic [COLOR_W-1:0] c0, c1, rgb;
    if (idx == 0) return BLACK;
    n = int'(stop_count_cfg);
    if (n < MIN_STOPS) n = MIN_STOPS;
    if (n > MAX_STOPS) n = MAX_STOPS;
    seg = 0;
    while (seg < n - 2 && int'(idx) > int'(stop_pos_tbl[seg + 1]))
      seg++;
    start_p = int'(stop_pos_tbl[seg]);
    end_p = int'(stop_pos_tbl[seg + 1]);
    span = end_p - start_p;
    t = (span > 0) ? ((int'(idx) - start_p) * int'(CH_MAX)) / span : 0;
    c0 = stop_rgb_tbl[seg];
    c1 = stop_rgb_tbl[seg + 1];
    for (ch = 0; ch < 3; ch++) begin
      a = int'(c0[ch*CH_W +: CH_W]);
      b = int'(c1[ch*CH_W +: CH_W]);
      v = a + ((b - a) * t) / int'(CH_MAX);
      if (v < 0) v = 0;
      if (v > int'(CH_MAX)) v = int'(CH_MAX);
      rgb[ch*CH_W +: CH_W] = v[CH_W-1:0];
    end
    return rgb;
  endfunction

  function automatic palette_req_t random_request();
    palette_req_t req;
    int pick, near;
    req.action = ($urandom_range(0, 99) < 15) ? ACT_LOAD : ACT_LOOKUP;
    req.slot = 3'($urandom);
    req.pos = 8'($urandom);
    req.rgb = 24'($urandom);
    req.idx = 8'($urandom);
    req.typed = 1'b0;
    req.typed_color = BLACK;
    if (req.action == ACT_LOOKUP) begin
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        req.idx = '0;
      end else if (pick < 5) begin
        // land on or right next to a stop
        near = int'(stop_pos_tbl[$urandom_range(0, MAX_STOPS - 1)])
               + int'($urandom_range(0, 4)) - 2;
        if (near < 0) near = 0;
        if (near > 255) near = 255;
        req.idx = 8'(near);
      end
    end
    return req;
  endfunction

  task automatic send_request(input palette_req_t req);
    int gap;
    gap = in_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= req.action;
    in_ch.stop_slot     <= req.slot;
    in_ch.stop_position <= req.pos;
    in_ch.stop_color    <= req.rgb;
    in_ch.palette_index <= req.idx;
    req_typed           <= req.typed;
    req_typed_color     <= req.typed_color;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // fresh stop table, ascending most of the time
  task automatic reload_stops();
    int p [MAX_STOPS];
    palette_req_t req;
    bit ordered;
    ordered = ($urandom_range(0, 3) != 0);
    foreach (p[i]) p[i] = $urandom_range(0, 255);
    if (ordered) begin
      p.sort();
      if ($urandom_range(0, 2) == 0) begin
        p[0] = 0;
        p[MAX_STOPS-1] = 255;
      end
    end
    foreach (p[i]) begin
      req = random_request();
      req.action = ACT_LOAD;
      req.slot = 3'(i);
      req.pos = 8'(p[i]);
      send_request(req);
    end
  endtask

  task automatic write_stop_count(input int value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.stop_count <= CNT_W'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for every lookup to come back, then let a trailing load finish
  task automatic settle();
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    logic [COLOR_W-1:0] exp_color;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready)
        stop_count_cfg = cfg_ch.stop_count;
      // retire results before new lookups join the queue
      if (out_ch.valid && out_ch.ready) begin
        if (pending_colors.size() == 0) begin
          $display("%0t: unexpected color %06h with no lookup pending", $time,
                   out_ch.color);
          error_count++;
        end else begin
          exp_color = pending_colors.pop_front();
          if (out_ch.color !== exp_color) begin
            $display("%0t: color mismatch, expected %06h, actual %06h", $time,
                     exp_color, out_ch.color);
            error_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_LOAD) begin
          if (int'(in_ch.stop_slot) < MAX_STOPS) begin
            stop_pos_tbl[in_ch.stop_slot] = in_ch.stop_position;
            stop_rgb_tbl[in_ch.stop_slot] = in_ch.stop_color;
          end
        end else begin
          pending_colors.push_back(req_typed ? req_typed_color
                                             : palette_color(in_ch.palette_index));
        end
      end
    end
  end

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = out_idle ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    stop_count_cfg      = STOP_CNT_RST;
    error_count         = 0;
    in_idle             = 1'b1;
    out_idle            = 1'b1;
    req_typed           = 1'b0;
    req_typed_color     = BLACK;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_LOAD;
    in_ch.stop_slot     = '0;
    in_ch.stop_position = '0;
    in_ch.stop_color    = '0;
    in_ch.palette_index = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.stop_count   = '0;
    foreach (stop_pos_tbl[i]) begin
      stop_pos_tbl[i] = '0;
      stop_rgb_tbl[i] = BLACK;
    end
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) send_request(directed_rows[r]);
    in_ch.valid <= 1'b0;
    settle();

    foreach (cfg_plan[p]) begin
      write_stop_count(cfg_plan[p]);
      in_idle = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) reload_stops();
      repeat (PHASE_ITEMS) send_request(random_request());
      in_ch.valid <= 1'b0;
      settle();
    end

    if (error_count == 0 && pending_colors.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
